FILE: hw/rtl/bounded_lifo_stack_assert.svh
// Assertion macros for the LIFO stack checker.
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// Clocked property with reset masking.
`define BLS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bounded_lifo_stack assertion failed");

// Implication form: when ante holds in a cycle, cons holds in the same cycle.
`define BLS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  `BLS_ASSERT(name, clk, rst_n, (ante) |-> (cons))

`endif

FILE: hw/rtl/bls_pkg.sv
package bls_pkg;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 9;
  localparam int LIMIT_W = 9;
  localparam int OUT_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    is_empty;
    logic    is_full;
    logic    use_data;
  } meta_t;

endpackage

FILE: hw/rtl/bls_ram.sv
module bls_ram #(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WORD_BITS-1:0]     wdata_i,
  output logic [WORD_BITS-1:0]     rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bls_ctrl.sv
module bls_ctrl
  import bls_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  cmd_e                     cmd_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic                     cfg_we_i,
  input  logic [LIMIT_W-1:0]       cfg_data_i,
  output logic                     ram_we_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_addr_o,
  output meta_t                    meta_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W0 = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CMP_W  = (CMP_W0 > POS_W) ? CMP_W0 : POS_W;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [CMP_W-1:0]   cnt_x, cnt_d_x, lim_x, pos_x, depth_x, eff_lim;
  logic               we, re;
  logic [AW-1:0]      addr;
  status_e            status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      if (accept_i) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign cnt_x   = CMP_W'(count_q);
  assign lim_x   = CMP_W'(limit_q);
  assign pos_x   = CMP_W'(pos_i);
  assign depth_x = CMP_W'(DEPTH);
  assign eff_lim = (lim_x > depth_x) ? depth_x : lim_x;

  always_comb begin
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    addr    = AW'(count_q);
    status  = ST_OK;
    unique case (cmd_i)
      CMD_PUSH: begin
        if (cnt_x >= eff_lim) begin
          status = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          re      = 1'b1;
          count_d = count_q - CNT_W'(1);
          addr    = AW'(count_q - CNT_W'(1));
        end
      end
      CMD_PEEK: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status = ST_BAD_POS;
        end else begin
          re   = 1'b1;
          addr = AW'(pos_x - CMP_W'(1));
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign cnt_d_x = CMP_W'(count_d);

  assign ram_we_o        = accept_i & we;
  assign ram_re_o        = accept_i & re;
  assign ram_addr_o      = addr;
  assign meta_o.status   = status;
  assign meta_o.is_empty = (count_d == '0);
  assign meta_o.is_full  = (cnt_d_x >= eff_lim);
  assign meta_o.use_data = re;

endmodule

FILE: hw/rtl/bounded_lifo_stack.sv
// Bounded LIFO stack of signed words.
// Input channel (in_valid_i / in_stall_o) carries one command word: push,
// pop, peek at a 1-based position from the bottom, or no-op. Output channel
// (out_valid_o / out_stall_i) returns one result word per command: the
// read value, a status code and the empty and full flags after the command.
// After acceptance a command passes the synchronous read of the entry memory,
// then the output register. Throughput is one command per cycle unless the
// receiver stalls; the single-port entry memory does at most one access per
// command and the entry count updates in the accept cycle.
// When the receiver stalls, the output register holds its word and one more
// command is taken into the read stage; then in_stall_o rises.
// The capacity register is written through cfg_valid_i / cfg_data_i, always
// ready; write it only while no command is in flight.
// Reset empties the stack and sets the capacity to 256. Entry contents are
// not cleared; only entries below the count are ever read.
module bounded_lifo_stack
  import bls_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [OUT_W-1:0]   push_value_i,
  input  logic [POS_W-1:0]          peek_position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [OUT_W-1:0]   read_value_o,
  output logic [1:0]                status_o,
  output logic                      is_empty_o,
  output logic                      is_full_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [LIMIT_W-1:0]        cfg_data_i
);

  localparam int AW    = $clog2(DEPTH);
  localparam int EXT_W = (WORD_BITS > OUT_W) ? WORD_BITS : OUT_W;

  logic                 in_accept, advance;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  logic [EXT_W-1:0]     wide_in, wide_out;
  meta_t                meta;

  logic                 p_valid_q;
  meta_t                p_meta_q;
  logic                 o_valid_q;
  meta_t                o_meta_q;
  logic [OUT_W-1:0]     o_data_q;

  assign advance     = p_valid_q & (~o_valid_q | ~out_stall_i);
  assign in_stall_o  = p_valid_q & ~advance;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign wide_in   = EXT_W'($unsigned(push_value_i));
  assign ram_wdata = wide_in[WORD_BITS-1:0];
  assign wide_out  = EXT_W'(ram_rdata);

  bls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .cmd_i      (cmd_e'(cmd_i)),
    .pos_i      (peek_position_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .meta_o     (meta)
  );

  bls_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        p_valid_q <= 1'b1;
      end else if (advance) begin
        p_valid_q <= 1'b0;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p_meta_q <= meta;
    end
    if (advance) begin
      o_meta_q <= p_meta_q;
      o_data_q <= p_meta_q.use_data ? wide_out[OUT_W-1:0] : '0;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign read_value_o = o_data_q;
  assign status_o     = o_meta_q.status;
  assign is_empty_o   = o_meta_q.is_empty;
  assign is_full_o    = o_meta_q.is_full;

endmodule

FILE: hw/rtl/bls_checker.sv
`include "bounded_lifo_stack_assert.svh"

module bls_checker
  import bls_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] read_value_o,
  input logic [1:0]              status_o,
  input logic                    is_empty_o,
  input logic                    is_full_o
);

  `BLS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_value_o) && $stable(status_o)))
  `BLS_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, read_value_o == '0)
  `BLS_ASSERT_IMPL(a_full_flag, clk_i, rst_ni, out_valid_o && status_o == ST_FULL, is_full_o)
  `BLS_ASSERT_IMPL(a_empty_flag, clk_i, rst_ni, out_valid_o && status_o == ST_EMPTY, is_empty_o)
  `BLS_ASSERT_IMPL(a_stall_backed, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .is_empty_o   (is_empty_o),
  .is_full_o    (is_full_o)
);
